### sv/huffman_tree_build_and_decode_assert.svh
// Assertion macros shared by the Huffman tree build and decode RTL.
`ifndef HUFFMAN_TREE_BUILD_AND_DECODE_ASSERT_SVH
`define HUFFMAN_TREE_BUILD_AND_DECODE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HTB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Huffman block assertion failed");

// Antecedent implies consequent in the following cycle.
`define HTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Huffman block assertion failed");

`endif

### sv/htb_pkg.sv
// Types and constants shared by the Huffman tree build and decode block.
`timescale 1ns / 1ps
package htb_pkg;

    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 21;
    localparam int CFG_W    = 6;
    localparam int CODE_W   = 31;
    localparam int LEN_W    = 5;

    localparam logic [NODE_W-1:0]   NO_NODE     = 6'd63;
    localparam logic [WEIGHT_W:0]   WEIGHT_CEIL = 22'h200000;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   parent;
    } t_node_ent;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } t_child_ent;

    typedef struct packed {
        logic                clr;
        logic                vld;
        logic                orphan;
        logic [WEIGHT_W-1:0] w;
        logic [NODE_W-1:0]   idx;
    } t_min_in;

    typedef struct packed {
        logic [WEIGHT_W:0] m1;
        logic [WEIGHT_W:0] m2;
        logic [NODE_W-1:0] x1;
        logic [NODE_W-1:0] x2;
    } t_min_out;

endpackage

### sv/huffman_tree_build_and_decode.sv
// Top level of the Huffman tree build and decode block.
// A load beat stores one leaf; the beat that completes the set of leaves starts the build:
// each of the n-1 merges scans nodes 0..n+i-1 through the node memory at one read a cycle,
// then writes back the two chosen children and the new parent node in turn, and the code
// table follows, climbing from each leaf to the root through the parent links. A decode
// beat does one child memory read, plus a symbol memory read when it reaches a leaf. One
// beat is worked on at a time.
`timescale 1ns / 1ps
`include "huffman_tree_build_and_decode_assert.svh"
module huffman_tree_build_and_decode
    import htb_pkg::*;
#(
    parameter int MAX_LEAVES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_symbol_count,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [7:0]          i_symbol,
    input  logic [15:0]         i_weight,
    input  logic                i_code_bit,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic [7:0]          o_symbol_res,
    output logic [CODE_W-1:0]   o_code,
    output logic [LEN_W-1:0]    o_code_length,
    output logic                o_last
);

    localparam int NODES = 2 * MAX_LEAVES - 1;
    localparam int LW    = (MAX_LEAVES > 2) ? $clog2(MAX_LEAVES) : 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_W1     = 10'b0000000100,
        S_W2     = 10'b0000001000,
        S_W3     = 10'b0000010000,
        S_ERD    = 10'b0000100000,
        S_EUP    = 10'b0001000000,
        S_ECMP   = 10'b0010000000,
        S_DCHILD = 10'b0100000000,
        S_DOUT   = 10'b1000000000
    } t_state;

    t_node_ent  nm [NODES];
    t_child_ent cm [NODES];
    logic [7:0] sm [MAX_LEAVES];

    t_state r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [NODE_W-1:0] r_loaded, n_loaded;
    logic              r_ready_tree, n_ready_tree;
    logic [NODE_W-1:0] r_walk, n_walk;
    logic [NODE_W-1:0] r_root, n_root;
    logic [NODE_W-1:0] r_nb, n_nb;
    logic [NODE_W-1:0] r_made, n_made;
    logic [NODE_W-1:0] r_j, n_j;
    logic [NODE_W-1:0] r_jq, n_jq;
    logic              r_dv, n_dv;
    logic [NODE_W-1:0] r_leaf, n_leaf;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_prev, n_prev;
    logic [CODE_W-1:0] r_code, n_code;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_bit, n_bit;

    logic              r_o_valid, n_o_valid;
    logic              r_o_kind, n_o_kind;
    logic [7:0]        r_o_sym, n_o_sym;
    logic [CODE_W-1:0] r_o_code, n_o_code;
    logic [LEN_W-1:0]  r_o_len, n_o_len;
    logic              r_o_last, n_o_last;

    logic              nm_we, nm_re, cm_we, cm_re, sm_we, sm_re;
    logic [NODE_W-1:0] nm_wa, nm_ra, cm_wa, cm_ra;
    logic [LW-1:0]     sm_wa, sm_ra;
    t_node_ent         nm_wd, nm_q;
    t_child_ent        cm_wd, cm_q;
    logic [7:0]        sm_wd, sm_q;

    t_min_in           min_in;
    t_min_out          min_out;

    logic              in_fire, out_free;
    logic [NODE_W-1:0] n_eff;
    logic [NODE_W:0]   root_calc;
    logic [WEIGHT_W:0] sum_w;
    logic [NODE_W-1:0] next_node;

    htb_min2 u_min2 (
        .i_clk (i_clk),
        .i_min (min_in),
        .o_min (min_out)
    );

    always_ff @(posedge i_clk) begin
        if (nm_we) nm[nm_wa] <= nm_wd;
        if (nm_re) nm_q <= nm[nm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) cm[cm_wa] <= cm_wd;
        if (cm_re) cm_q <= cm[cm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) sm[sm_wa] <= sm_wd;
        if (sm_re) sm_q <= sm[sm_ra];
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_o_valid || i_out_ready;

    always_comb begin
        if (r_cfg < 6'd2) begin
            n_eff = 6'd2;
        end else if (r_cfg > NODE_W'(MAX_LEAVES)) begin
            n_eff = NODE_W'(MAX_LEAVES);
        end else begin
            n_eff = r_cfg;
        end
    end

    assign root_calc = {n_eff, 1'b0} - 7'd2;
    assign sum_w     = min_out.m1 + min_out.m2;
    assign next_node = r_bit ? cm_q.right : cm_q.left;

    always_comb begin
        n_state      = r_state;
        n_loaded     = r_loaded;
        n_ready_tree = r_ready_tree;
        n_walk       = r_walk;
        n_root       = r_root;
        n_nb         = r_nb;
        n_made       = r_made;
        n_j          = r_j;
        n_jq         = r_jq;
        n_dv         = 1'b0;
        n_leaf       = r_leaf;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_code       = r_code;
        n_len        = r_len;
        n_bit        = r_bit;
        n_o_valid    = r_o_valid && !i_out_ready;
        n_o_kind     = r_o_kind;
        n_o_sym      = r_o_sym;
        n_o_code     = r_o_code;
        n_o_len      = r_o_len;
        n_o_last     = r_o_last;
        nm_we = 1'b0; nm_wa = '0; nm_wd = '0; nm_re = 1'b0; nm_ra = '0;
        cm_we = 1'b0; cm_wa = '0; cm_wd = '0; cm_re = 1'b0; cm_ra = '0;
        sm_we = 1'b0; sm_wa = '0; sm_wd = '0; sm_re = 1'b0; sm_ra = '0;
        min_in        = '0;
        min_in.w      = nm_q.weight;
        min_in.idx    = r_jq;
        min_in.orphan = (nm_q.parent == NO_NODE);

        case (r_state)
            S_IDLE: begin
                if (in_fire && !i_mode) begin
                    nm_we        = 1'b1;
                    nm_wa        = r_loaded;
                    nm_wd.weight = WEIGHT_W'(i_weight);
                    nm_wd.parent = NO_NODE;
                    sm_we        = 1'b1;
                    sm_wa        = r_loaded[LW-1:0];
                    sm_wd        = i_symbol;
                    n_ready_tree = 1'b0;
                    if (r_loaded + 6'd1 >= n_eff) begin
                        n_loaded   = '0;
                        n_nb       = n_eff;
                        n_made     = n_eff;
                        n_root     = root_calc[NODE_W-1:0];
                        n_j        = '0;
                        min_in.clr = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        n_loaded = r_loaded + 6'd1;
                    end
                end else if (in_fire && r_ready_tree) begin
                    cm_re   = 1'b1;
                    cm_ra   = r_walk;
                    n_bit   = i_code_bit;
                    n_state = S_DCHILD;
                end
            end
            S_SCAN: begin
                min_in.vld = r_dv;
                if (r_j < r_made) begin
                    nm_re = 1'b1;
                    nm_ra = r_j;
                    n_j   = r_j + 6'd1;
                    n_jq  = r_j;
                    n_dv  = 1'b1;
                end else if (!r_dv) begin
                    n_state = S_W1;
                end
            end
            S_W1: begin
                nm_we        = 1'b1;
                nm_wa        = min_out.x1;
                nm_wd.weight = min_out.m1[WEIGHT_W-1:0];
                nm_wd.parent = r_made;
                n_state      = S_W2;
            end
            S_W2: begin
                nm_we        = 1'b1;
                nm_wa        = min_out.x2;
                nm_wd.weight = min_out.m2[WEIGHT_W-1:0];
                nm_wd.parent = r_made;
                n_state      = S_W3;
            end
            S_W3: begin
                nm_we        = 1'b1;
                nm_wa        = r_made;
                nm_wd.weight = sum_w[WEIGHT_W-1:0];
                nm_wd.parent = NO_NODE;
                cm_we        = 1'b1;
                cm_wa        = r_made;
                cm_wd.left   = min_out.x1;
                cm_wd.right  = min_out.x2;
                if (r_made == r_root) begin
                    n_ready_tree = 1'b1;
                    n_walk       = r_root;
                    n_leaf       = '0;
                    n_state      = S_ERD;
                end else begin
                    n_made     = r_made + 6'd1;
                    n_j        = '0;
                    min_in.clr = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_ERD: begin
                nm_re   = 1'b1;
                nm_ra   = r_leaf;
                sm_re   = 1'b1;
                sm_ra   = r_leaf[LW-1:0];
                n_cur   = r_leaf;
                n_code  = '0;
                n_len   = '0;
                n_state = S_EUP;
            end
            S_EUP: begin
                if (nm_q.parent == NO_NODE || r_len == 5'd31) begin
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = 1'b0;
                        n_o_sym   = sm_q;
                        n_o_code  = r_code;
                        n_o_len   = r_len;
                        n_o_last  = (r_leaf + 6'd1 == r_nb);
                        n_leaf    = r_leaf + 6'd1;
                        n_state   = (r_leaf + 6'd1 == r_nb) ? S_IDLE : S_ERD;
                    end
                end else begin
                    nm_re   = 1'b1;
                    nm_ra   = nm_q.parent;
                    cm_re   = 1'b1;
                    cm_ra   = nm_q.parent;
                    n_prev  = r_cur;
                    n_cur   = nm_q.parent;
                    n_state = S_ECMP;
                end
            end
            S_ECMP: begin
                if (cm_q.left != r_prev) begin
                    n_code = r_code | (CODE_W'(1) << r_len);
                end
                n_len   = r_len + 5'd1;
                n_state = S_EUP;
            end
            S_DCHILD: begin
                if (next_node < r_nb) begin
                    sm_re   = 1'b1;
                    sm_ra   = next_node[LW-1:0];
                    n_walk  = r_root;
                    n_state = S_DOUT;
                end else begin
                    n_walk  = next_node;
                    n_state = S_IDLE;
                end
            end
            S_DOUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = 1'b1;
                    n_o_sym   = sm_q;
                    n_o_code  = '0;
                    n_o_len   = '0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg        <= 6'd2;
            r_loaded     <= '0;
            r_ready_tree <= 1'b0;
            r_walk       <= '0;
            r_root       <= '0;
            r_nb         <= 6'd2;
            r_dv         <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_symbol_count;
            r_loaded     <= n_loaded;
            r_ready_tree <= n_ready_tree;
            r_walk       <= n_walk;
            r_root       <= n_root;
            r_nb         <= n_nb;
            r_dv         <= n_dv;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_made   <= n_made;
        r_j      <= n_j;
        r_jq     <= n_jq;
        r_leaf   <= n_leaf;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_code   <= n_code;
        r_len    <= n_len;
        r_bit    <= n_bit;
        r_o_kind <= n_o_kind;
        r_o_sym  <= n_o_sym;
        r_o_code <= n_o_code;
        r_o_len  <= n_o_len;
        r_o_last <= n_o_last;
    end

    assign o_out_valid   = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_symbol_res  = r_o_sym;
    assign o_code        = r_o_code;
    assign o_code_length = r_o_len;
    assign o_last        = r_o_last;

    `HTB_ASSERT_NOW(a_merge_distinct, r_state == S_W1, min_out.x1 != min_out.x2)
    `HTB_ASSERT_NOW(a_made_in_tree, r_state == S_SCAN, r_made <= r_root)
    `HTB_ASSERT_NOW(a_depth_bound, r_state == S_ECMP, r_len != 5'd31)
    `HTB_ASSERT_NEXT(a_walk_root, r_state == S_DOUT, r_walk == r_root)

endmodule

### sv/htb_min2.sv
// Running tracker of the two smallest parentless node weights during a scan.
`timescale 1ns / 1ps
module htb_min2
    import htb_pkg::*;
(
    input  logic     i_clk,
    input  t_min_in  i_min,
    output t_min_out o_min
);

    logic [WEIGHT_W:0] r_m1, r_m2;
    logic [NODE_W-1:0] r_x1, r_x2;
    logic [WEIGHT_W:0] w_ext;

    assign w_ext = {1'b0, i_min.w};

    always_ff @(posedge i_clk) begin
        if (i_min.clr) begin
            r_m1 <= WEIGHT_CEIL;
            r_m2 <= WEIGHT_CEIL;
            r_x1 <= '0;
            r_x2 <= '0;
        end else if (i_min.vld && i_min.orphan) begin
            if (w_ext < r_m1) begin
                r_m2 <= r_m1;
                r_x2 <= r_x1;
                r_m1 <= w_ext;
                r_x1 <= i_min.idx;
            end else if (w_ext < r_m2) begin
                r_m2 <= w_ext;
                r_x2 <= i_min.idx;
            end
        end
    end

    assign o_min.m1 = r_m1;
    assign o_min.m2 = r_m2;
    assign o_min.x1 = r_x1;
    assign o_min.x2 = r_x2;

endmodule
